// ----- hw/rtl/cbg_pkg.sv -----
// ----------------------------------------------------------------------------
// Circuit breaker gate package
// Shared widths, mode and command codes, register indexes and bundle types.
// ----------------------------------------------------------------------------
package cbg_pkg;

   // Width of the tick time base.
   localparam int TIME_WIDTH  = 48;
   localparam int COUNT_WIDTH = 8;
   localparam int LIMIT_WIDTH = 8;
   localparam int COOL_WIDTH  = 32;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 32;

   // Breaker modes.
   localparam logic [1:0] MODE_CLOSED = 2'd0;
   localparam logic [1:0] MODE_OPEN   = 2'd1;
   localparam logic [1:0] MODE_HALF   = 2'd2;

   // Event commands.
   localparam logic [1:0] CMD_REQUEST = 2'd0;
   localparam logic [1:0] CMD_SUCCESS = 2'd1;
   localparam logic [1:0] CMD_FAILURE = 2'd2;
   localparam logic [1:0] CMD_NEUTRAL = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] REG_FAILURE_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_COOLDOWN_TICKS = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PROBE_LIMIT    = 2'd2;

   // Configuration register reset values.
   localparam logic [LIMIT_WIDTH-1:0] FAILURE_LIMIT_RESET  = 8'd5;
   localparam logic [COOL_WIDTH-1:0]  COOLDOWN_TICKS_RESET = 32'd1000;
   localparam logic [LIMIT_WIDTH-1:0] PROBE_LIMIT_RESET    = 8'd1;

   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] failure_limit;
      logic [COOL_WIDTH-1:0]  cooldown_ticks;
      logic [LIMIT_WIDTH-1:0] probe_limit;
   } cbg_cfg_type;

   typedef struct packed {
      logic [1:0]             mode;
      logic [COUNT_WIDTH-1:0] fail_count;
      logic [COUNT_WIDTH-1:0] probe_count;
      logic [TIME_WIDTH-1:0]  reopen_time;
   } cbg_state_type;

   typedef struct packed {
      logic                   admitted;
      logic [1:0]             mode;
      logic [COUNT_WIDTH-1:0] failure_count;
      logic [COUNT_WIDTH-1:0] probe_count;
      logic [TIME_WIDTH-1:0]  retry_time;
   } cbg_result_type;

endpackage

// ----- hw/rtl/cbg_req_if.sv -----
// ----------------------------------------------------------------------------
// Circuit breaker gate event channel
// Valid/ready channel carrying one event: command and current tick.
// ----------------------------------------------------------------------------
interface cbg_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic [cbg_pkg::TIME_WIDTH-1:0] now_tick;

   modport source (output valid, output command, output now_tick, input ready);
   modport sink   (input valid, input command, input now_tick, output ready);
endinterface

// ----- hw/rtl/cbg_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Circuit breaker gate result channel
// Valid/ready channel carrying the verdict and a snapshot of the state.
// ----------------------------------------------------------------------------
interface cbg_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            admitted;
   logic [1:0]                      mode;
   logic [cbg_pkg::COUNT_WIDTH-1:0] failure_count;
   logic [cbg_pkg::COUNT_WIDTH-1:0] probe_count;
   logic [cbg_pkg::TIME_WIDTH-1:0]  retry_time;

   modport source (output valid, output admitted, output mode, output failure_count,
                   output probe_count, output retry_time, input ready);
   modport sink   (input valid, input admitted, input mode, input failure_count,
                   input probe_count, input retry_time, output ready);
endinterface

// ----- hw/rtl/cbg_csr_if.sv -----
// ----------------------------------------------------------------------------
// Circuit breaker gate configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface cbg_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cbg_pkg::CSR_IDX_WIDTH-1:0]  index;
   logic [cbg_pkg::CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/circuit_breaker_gate_unit.sv -----
// Path: an accepted event passes through the input register and then the output register.
// Throughput: one event per cycle unless results stall; the state register closes its loop through
// one 48-bit compare and the short counter updates in the evaluation logic.
// Stalls: the input waits only while both registers are full and the result is not taken.
// Reset: synchronous; clears the mode to closed, counters and retry time to zero
// and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// Circuit breaker gate unit
// Admission gate with closed, open and half-open modes. Events are captured in
// an input register, evaluated against the breaker state, and the verdict plus
// a state snapshot is held in an output register.
// ----------------------------------------------------------------------------
module circuit_breaker_gate_unit (
   input logic       clock,
   input logic       reset,
   cbg_req_if.sink   req_chan,
   cbg_rsp_if.source rsp_chan,
   cbg_csr_if.sink   csr_chan
);

   cbg_pkg::cbg_cfg_type    cfg_ff, cfg_in;
   cbg_pkg::cbg_state_type  state_ff, state_in;
   cbg_pkg::cbg_result_type out_ff, out_in;

   logic                           s1_valid_ff, s1_valid_in;
   logic [1:0]                     s1_cmd_ff;
   logic [cbg_pkg::TIME_WIDTH-1:0] s1_now_ff;
   logic                           out_valid_ff, out_valid_in;

   logic                   req_take;
   logic                   s1_adv;
   cbg_pkg::cbg_state_type eval_state;
   logic                   eval_admitted;

   // Configuration writes; writes beyond the register list are dropped.
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            cbg_pkg::REG_FAILURE_LIMIT:
               cfg_in.failure_limit  = csr_chan.data[cbg_pkg::LIMIT_WIDTH-1:0];
            cbg_pkg::REG_COOLDOWN_TICKS:
               cfg_in.cooldown_ticks = csr_chan.data[cbg_pkg::COOL_WIDTH-1:0];
            cbg_pkg::REG_PROBE_LIMIT:
               cfg_in.probe_limit    = csr_chan.data[cbg_pkg::LIMIT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline flow control: the input stage moves on when the output register
   // is empty or its transaction is being taken.
   assign s1_adv         = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_chan.ready);

   // Event evaluation.
   cbg_eval u_eval (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .command   (s1_cmd_ff),
      .now_tick  (s1_now_ff),
      .nxt_state (eval_state),
      .admitted  (eval_admitted)
   );

   assign state_in = s1_adv ? eval_state : state_ff;

   always_comb begin
      out_in               = out_ff;
      if (s1_adv) begin
         out_in.admitted      = eval_admitted;
         out_in.mode          = eval_state.mode;
         out_in.failure_count = eval_state.fail_count;
         out_in.probe_count   = eval_state.probe_count;
         out_in.retry_time    = eval_state.reopen_time;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.failure_limit  <= cbg_pkg::FAILURE_LIMIT_RESET;
         cfg_ff.cooldown_ticks <= cbg_pkg::COOLDOWN_TICKS_RESET;
         cfg_ff.probe_limit    <= cbg_pkg::PROBE_LIMIT_RESET;
         state_ff.mode         <= cbg_pkg::MODE_CLOSED;
         state_ff.fail_count   <= '0;
         state_ff.probe_count  <= '0;
         state_ff.reopen_time  <= '0;
         s1_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff <= req_chan.command;
         s1_now_ff <= req_chan.now_tick;
      end
      out_ff <= out_in;
   end

   // Result channel.
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.admitted      = out_ff.admitted;
   assign rsp_chan.mode          = out_ff.mode;
   assign rsp_chan.failure_count = out_ff.failure_count;
   assign rsp_chan.probe_count   = out_ff.probe_count;
   assign rsp_chan.retry_time    = out_ff.retry_time;

`ifndef SYNTHESIS
   // Reset leaves the breaker closed with no retry time.
   a_reset_closed: assert property (@(posedge clock)
      $fell(reset) |-> (state_ff.mode == cbg_pkg::MODE_CLOSED && state_ff.reopen_time == '0))
      else $error("breaker not closed after reset");

   // Failures are only counted while closed.
   a_fail_closed_only: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode != cbg_pkg::MODE_CLOSED |-> state_ff.fail_count == '0)
      else $error("failure count outside closed mode");

   // Probes are only in flight while half-open.
   a_probe_half_only: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode != cbg_pkg::MODE_HALF |-> state_ff.probe_count == '0)
      else $error("probe count outside half-open mode");

   // An admitted request never leaves the breaker open.
   a_admit_not_open: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.admitted |-> out_ff.mode != cbg_pkg::MODE_OPEN)
      else $error("admitted transaction reports open mode");

   // An accepted transaction always lands in the input stage.
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted transaction lost");
`endif

endmodule

// ----- hw/rtl/cbg_eval.sv -----
// ----------------------------------------------------------------------------
// Circuit breaker gate event evaluation
// Combinational next-state and verdict logic for one event.
// ----------------------------------------------------------------------------
module cbg_eval (
   input  cbg_pkg::cbg_state_type        cur_state,
   input  cbg_pkg::cbg_cfg_type          cfg,
   input  logic [1:0]                    command,
   input  logic [cbg_pkg::TIME_WIDTH-1:0] now_tick,
   output cbg_pkg::cbg_state_type        nxt_state,
   output logic                          admitted
);

   logic [cbg_pkg::LIMIT_WIDTH-1:0] eff_fail_limit;
   logic [cbg_pkg::LIMIT_WIDTH-1:0] eff_probe_limit;
   logic [cbg_pkg::COOL_WIDTH-1:0]  eff_cooldown;
   logic [cbg_pkg::TIME_WIDTH:0]    trip_sum;
   logic [cbg_pkg::TIME_WIDTH-1:0]  trip_time;

   // A zero register counts as the lower bound of one.
   assign eff_fail_limit  = (cfg.failure_limit == '0) ? cbg_pkg::LIMIT_WIDTH'(1)
                                                      : cfg.failure_limit;
   assign eff_probe_limit = (cfg.probe_limit == '0) ? cbg_pkg::LIMIT_WIDTH'(1)
                                                    : cfg.probe_limit;
   assign eff_cooldown    = (cfg.cooldown_ticks == '0) ? cbg_pkg::COOL_WIDTH'(1)
                                                       : cfg.cooldown_ticks;

   // Reopen time, saturated at the largest tick value on carry out.
   assign trip_sum  = {1'b0, now_tick}
                    + {{(cbg_pkg::TIME_WIDTH + 1 - cbg_pkg::COOL_WIDTH){1'b0}}, eff_cooldown};
   assign trip_time = trip_sum[cbg_pkg::TIME_WIDTH] ? '1 : trip_sum[cbg_pkg::TIME_WIDTH-1:0];

   // Event decode and state update.
   always_comb begin
      logic                            refused;
      logic [1:0]                      mode_v;
      logic [cbg_pkg::COUNT_WIDTH-1:0] probe_v;
      logic [cbg_pkg::COUNT_WIDTH-1:0] fail_v;

      nxt_state = cur_state;
      admitted  = 1'b0;
      refused   = 1'b0;
      mode_v    = cur_state.mode;
      probe_v   = cur_state.probe_count;
      fail_v    = cur_state.fail_count;

      case (command)
         cbg_pkg::CMD_REQUEST: begin
            // An expired open period turns into half-open probing.
            if (cur_state.mode == cbg_pkg::MODE_OPEN) begin
               if (now_tick < cur_state.reopen_time) begin
                  refused = 1'b1;
               end else begin
                  mode_v  = cbg_pkg::MODE_HALF;
                  probe_v = '0;
               end
            end
            if (!refused && mode_v == cbg_pkg::MODE_HALF) begin
               if (probe_v >= eff_probe_limit) begin
                  refused = 1'b1;
               end else begin
                  probe_v = probe_v + 1'b1;
               end
            end
            nxt_state.mode        = mode_v;
            nxt_state.probe_count = probe_v;
            admitted              = !refused;
         end
         cbg_pkg::CMD_SUCCESS: begin
            nxt_state.mode        = cbg_pkg::MODE_CLOSED;
            nxt_state.fail_count  = '0;
            nxt_state.probe_count = '0;
            nxt_state.reopen_time = '0;
         end
         cbg_pkg::CMD_FAILURE: begin
            if (cur_state.mode == cbg_pkg::MODE_HALF) begin
               nxt_state.mode        = cbg_pkg::MODE_OPEN;
               nxt_state.fail_count  = '0;
               nxt_state.probe_count = '0;
               nxt_state.reopen_time = trip_time;
            end else if (cur_state.mode != cbg_pkg::MODE_OPEN) begin
               // Saturating count of consecutive failures while closed.
               if (fail_v != '1) begin
                  fail_v = fail_v + 1'b1;
               end
               if (fail_v >= eff_fail_limit) begin
                  nxt_state.mode        = cbg_pkg::MODE_OPEN;
                  nxt_state.fail_count  = '0;
                  nxt_state.probe_count = '0;
                  nxt_state.reopen_time = trip_time;
               end else begin
                  nxt_state.fail_count = fail_v;
               end
            end
         end
         default: begin
            // Neutral event releases one probe while half-open.
            if (cur_state.mode == cbg_pkg::MODE_HALF && cur_state.probe_count != '0) begin
               nxt_state.probe_count = cur_state.probe_count - 1'b1;
            end
         end
      endcase
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circuit breaker gate unit testbench
// Drives event transactions and register writes into the gate and checks
// every result transaction against a cycle-free model of the breaker. A set
// of directed tests covers the trip, probe and saturation corners. Random
// traffic with random idle cycles on both channels follows.
// ----------------------------------------------------------------------------
module testbench;
   import cbg_pkg::*;

   // Index with no register behind it; writes to it must change nothing.
   localparam logic [CSR_IDX_WIDTH-1:0] REG_UNUSED = 2'd3;
   localparam logic [TIME_WIDTH-1:0]    TICK_MAX   = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cbg_req_if req_bus ();
   cbg_rsp_if rsp_bus ();
   cbg_csr_if csr_bus ();

   circuit_breaker_gate_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #6 clock = ~clock;

   // Model copy of the configuration registers.
   logic [LIMIT_WIDTH-1:0] fail_limit_cfg;
   logic [COOL_WIDTH-1:0]  cooldown_cfg;
   logic [LIMIT_WIDTH-1:0] probe_limit_cfg;

   // Model copy of the breaker state.
   logic [1:0]             gate_mode;
   logic [COUNT_WIDTH-1:0] fail_cnt;
   logic [COUNT_WIDTH-1:0] probe_cnt;
   logic [TIME_WIDTH-1:0]  reopen_at;

   // Results still owed by the gate, oldest first.
   cbg_result_type pending_verdicts[$];

   int unsigned mismatch_count = 0;
   int          rsp_hold       = 0;
   logic        steady_flow    = 1'b0;
   logic [TIME_WIDTH-1:0] tick_base;

   // Idle cycles before the next transaction on either channel.
   function automatic int draw_wait();
      return steady_flow ? 0 : $urandom_range(0, 17);
   endfunction

   // Open the breaker until now plus cooldown, saturated at the time maximum.
   function automatic void open_gate(input logic [TIME_WIDTH-1:0] now);
      logic [TIME_WIDTH:0] sum;
      sum = {1'b0, now} + ((cooldown_cfg == '0) ? 1 : cooldown_cfg);
      gate_mode = MODE_OPEN;
      fail_cnt  = '0;
      probe_cnt = '0;
      reopen_at = sum[TIME_WIDTH] ? TICK_MAX : sum[TIME_WIDTH-1:0];
   endfunction

   // Apply one event to the model and return the verdict with a state snapshot.
   function automatic cbg_result_type predict_gate(input logic [1:0] cmd,
                                                   input logic [TIME_WIDTH-1:0] now);
      cbg_result_type         snap;
      logic                   refused;
      logic [LIMIT_WIDTH-1:0] probe_cap;
      logic [LIMIT_WIDTH-1:0] fail_cap;
      snap      = '0;
      refused   = 1'b0;
      probe_cap = (probe_limit_cfg == '0) ? 8'd1 : probe_limit_cfg;
      fail_cap  = (fail_limit_cfg == '0) ? 8'd1 : fail_limit_cfg;
      case (cmd)
         CMD_REQUEST: begin
            if (gate_mode == MODE_OPEN) begin
               if (now < reopen_at) begin
                  refused = 1'b1;
               end else begin
                  gate_mode = MODE_HALF;
                  probe_cnt = '0;
               end
            end
            if (!refused && gate_mode == MODE_HALF) begin
               if (probe_cnt >= probe_cap) refused = 1'b1;
               else probe_cnt++;
            end
            snap.admitted = !refused;
         end
         CMD_SUCCESS: begin
            gate_mode = MODE_CLOSED;
            fail_cnt  = '0;
            probe_cnt = '0;
            reopen_at = '0;
         end
         CMD_FAILURE: begin
            if (gate_mode == MODE_HALF) begin
               open_gate(now);
            end else if (gate_mode != MODE_OPEN) begin
               if (fail_cnt != 8'hFF) fail_cnt++;
               if (fail_cnt >= fail_cap) open_gate(now);
            end
         end
         default: begin
            if (gate_mode == MODE_HALF && probe_cnt != '0) probe_cnt--;
         end
      endcase
      snap.mode          = gate_mode;
      snap.failure_count = fail_cnt;
      snap.probe_count   = probe_cnt;
      snap.retry_time    = reopen_at;
      return snap;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
   endtask

   // Compare one result transaction with the oldest outstanding verdict.
   task automatic check_result();
      cbg_result_type want;
      if (pending_verdicts.size() == 0) begin
         report_mismatch("unrequested result", 64'd0, 64'd1);
      end else begin
         want = pending_verdicts.pop_front();
         if (rsp_bus.admitted !== want.admitted)
            report_mismatch("admitted", want.admitted, rsp_bus.admitted);
         if (rsp_bus.mode !== want.mode)
            report_mismatch("mode", want.mode, rsp_bus.mode);
         if (rsp_bus.failure_count !== want.failure_count)
            report_mismatch("failure_count", want.failure_count, rsp_bus.failure_count);
         if (rsp_bus.probe_count !== want.probe_count)
            report_mismatch("probe_count", want.probe_count, rsp_bus.probe_count);
         if (rsp_bus.retry_time !== want.retry_time)
            report_mismatch("retry_time", want.retry_time, rsp_bus.retry_time);
      end
   endtask

   // Result side: check each accepted transaction, then stall for a random time.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         check_result();
         rsp_hold = draw_wait();
         rsp_bus.ready <= (rsp_hold == 0);
      end else if (!rsp_bus.ready) begin
         if (rsp_hold <= 1) begin
            rsp_bus.ready <= 1'b1;
            rsp_hold = 0;
         end else begin
            rsp_hold--;
         end
      end
   end

   // Send one event transaction and record the verdict it must produce.
   task automatic send_event(input logic [1:0] cmd, input logic [TIME_WIDTH-1:0] now);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.now_tick <= now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_verdicts.push_back(predict_gate(cmd, now));
   endtask

   // Stop sending and wait until every outstanding result has arrived.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
   endtask

   // One register write; the channel stays valid for a following write.
   task automatic write_register(input logic [CSR_IDX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         REG_FAILURE_LIMIT:  fail_limit_cfg  = value[LIMIT_WIDTH-1:0];
         REG_COOLDOWN_TICKS: cooldown_cfg    = value[COOL_WIDTH-1:0];
         REG_PROBE_LIMIT:    probe_limit_cfg = value[LIMIT_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // Reprogram all registers once the gate has gone idle.
   task automatic configure_gate(input logic [CSR_DATA_WIDTH-1:0] fail_limit,
                                 input logic [CSR_DATA_WIDTH-1:0] cooldown,
                                 input logic [CSR_DATA_WIDTH-1:0] probes,
                                 input logic with_spare = 1'b0);
      wait_for_results();
      if (with_spare) write_register(REG_UNUSED, 32'hDEAD_BEEF);
      write_register(REG_FAILURE_LIMIT, fail_limit);
      write_register(REG_COOLDOWN_TICKS, cooldown);
      write_register(REG_PROBE_LIMIT, probes);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [1:0] pick_command(input int pct_req, input int pct_ok,
                                               input int pct_fail);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < pct_req) return CMD_REQUEST;
      if (r < pct_req + pct_ok) return CMD_SUCCESS;
      if (r < pct_req + pct_ok + pct_fail) return CMD_FAILURE;
      return CMD_NEUTRAL;
   endfunction

   // Mostly a slowly rising time base, often landing right at the retry time
   // while open, with an occasional arbitrary value.
   function automatic logic [TIME_WIDTH-1:0] pick_tick();
      int unsigned r;
      logic [63:0] word;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         word = {$urandom, $urandom};
         return word[TIME_WIDTH-1:0];
      end
      if (gate_mode == MODE_OPEN && r < 50) begin
         case ($urandom_range(0, 3))
            0: tick_base = reopen_at - 1;
            1: tick_base = reopen_at;
            2: tick_base = reopen_at + 1;
            default: tick_base = reopen_at + $urandom_range(0, 50);
         endcase
         return tick_base;
      end
      tick_base = tick_base + $urandom_range(0, 12);
      return tick_base;
   endfunction

   // Trip on consecutive failures, refuse while open, probe, release, re-trip, close.
   task automatic test_default_cycle();
      send_event(CMD_REQUEST, 48'd100);
      for (int n = 0; n < 5; n++) send_event(CMD_FAILURE, 48'd101 + n);
      send_event(CMD_REQUEST, reopen_at - 1);
      send_event(CMD_FAILURE, reopen_at - 1);
      send_event(CMD_REQUEST, reopen_at);
      send_event(CMD_REQUEST, reopen_at);
      send_event(CMD_NEUTRAL, reopen_at + 1);
      send_event(CMD_NEUTRAL, reopen_at + 1);
      send_event(CMD_REQUEST, reopen_at + 2);
      send_event(CMD_FAILURE, reopen_at + 3);
      send_event(CMD_SUCCESS, 48'd2000);
   endtask

   // Zero registers behave as one: a single failure trips for one tick.
   task automatic test_zero_registers();
      configure_gate(32'd0, 32'd0, 32'd0);
      send_event(CMD_FAILURE, 48'd50);
      send_event(CMD_REQUEST, 48'd50);
      send_event(CMD_REQUEST, 48'd51);
      send_event(CMD_SUCCESS, 48'd52);
      send_event(CMD_NEUTRAL, 48'd52);
   endtask

   // Retry time saturates at the time maximum; upper data bits are dropped.
   task automatic test_time_saturation();
      configure_gate(32'hFFFF_FF01, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_event(CMD_FAILURE, 48'hFFFF_FFFF_0000);
      send_event(CMD_REQUEST, TICK_MAX - 1);
      send_event(CMD_REQUEST, TICK_MAX);
      send_event(CMD_REQUEST, TICK_MAX);
      send_event(CMD_FAILURE, 48'd0);
      send_event(CMD_SUCCESS, TICK_MAX);
   endtask

   task automatic run_traffic(input int count, input int pct_req, input int pct_ok,
                              input int pct_fail);
      logic [1:0] cmd;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 39) == 0) steady_flow = !steady_flow;
         if ($urandom_range(0, 59) == 0) wait_for_results();
         cmd = pick_command(pct_req, pct_ok, pct_fail);
         send_event(cmd, pick_tick());
      end
   endtask

   // Random event streams under a series of register settings.
   task automatic test_random_traffic();
      logic [63:0] word;
      tick_base = 48'd5000;
      configure_gate(32'd3, 32'd20, 32'd2);
      run_traffic(80, 40, 10, 35);

      steady_flow = 1'b1;
      configure_gate($urandom_range(1, 6), $urandom_range(1, 40), $urandom_range(1, 4));
      run_traffic(80, 40, 8, 37);

      // Wide probe window with the shortest cooldown.
      steady_flow = 1'b0;
      configure_gate(32'd1, 32'd1, 32'd255);
      run_traffic(60, 60, 5, 15);

      // Largest failure limit near the end of time, mostly failures.
      tick_base = TICK_MAX - $urandom_range(0, 20000);
      configure_gate(32'd255, $urandom, 32'd1);
      run_traffic(280, 2, 0, 97);

      word = {$urandom, $urandom};
      tick_base = word[TIME_WIDTH-1:0];
      configure_gate($urandom, $urandom, $urandom);
      run_traffic(70, 40, 10, 35);

      configure_gate(FAILURE_LIMIT_RESET, COOLDOWN_TICKS_RESET, PROBE_LIMIT_RESET);
      run_traffic(70, 40, 10, 35);
      wait_for_results();
   endtask

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.command  = CMD_REQUEST;
      req_bus.now_tick = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = REG_FAILURE_LIMIT;
      csr_bus.data     = '0;
      rsp_bus.ready    = 1'b0;
      fail_limit_cfg   = FAILURE_LIMIT_RESET;
      cooldown_cfg     = COOLDOWN_TICKS_RESET;
      probe_limit_cfg  = PROBE_LIMIT_RESET;
      gate_mode        = MODE_CLOSED;
      fail_cnt         = '0;
      probe_cnt        = '0;
      reopen_at        = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_default_cycle();
      test_zero_registers();
      test_time_saturation();
      test_random_traffic();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // Watchdog against a stalled handshake.
   initial begin
      #5000000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
